// ===== design/txcon_pkg.sv =====
package txcon_pkg;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = ROWS * COLUMNS;
	localparam int ADDR_W      = $clog2(CELLS);
	localparam int ROW_W       = $clog2(ROWS);
	localparam int COL_W       = $clog2(COLUMNS + 1);
	localparam int SCROLL_END  = (ROWS - 1) * COLUMNS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'd32;
	localparam logic [7:0] COLOR_RESET  = 8'd15;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef enum logic [2:0] {
		CMD_CHAR,
		CMD_NEWLINE,
		CMD_CLEAR,
		CMD_READ,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [7:0]        ch;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_wr_t;

	typedef struct packed {
		logic pop;
		logic valid;
	} q_rd_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} in_item_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_color;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_SCROLL,
		ST_BLANK,
		ST_DONE
	} state_t;

endpackage

// ===== design/txcon_front.sv =====
module txcon_front import txcon_pkg::*; (
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     q_full,
	output q_wr_t    q_wr,
	output cmd_t     q_data
);

	logic in_range;

	assign in_range = (32'(in_item.read_row) < ROWS) && (32'(in_item.read_col) < COLUMNS);

	always_comb begin
		q_data.ch   = in_item.char_code;
		q_data.addr = ADDR_W'(32'(in_item.read_row) * COLUMNS + 32'(in_item.read_col));
		priority if (in_item.operation == OP_PUT) begin
			q_data.kind = (in_item.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_CHAR;
		end else if (in_item.operation == OP_CLEAR) begin
			q_data.kind = CMD_CLEAR;
		end else if (in_item.operation == OP_READ && in_range) begin
			q_data.kind = CMD_READ;
		end else begin
			q_data.kind = CMD_NOP;
		end
	end

	assign in_ready    = !q_full;
	assign q_wr.push   = in_valid && !q_full;
	assign q_wr.full   = q_full;

endmodule

// ===== design/txcon_queue.sv =====
module txcon_queue import txcon_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t wr,
	input  cmd_t  wr_data,
	output logic  full,
	input  q_rd_t rd,
	output logic  valid,
	output cmd_t  rd_data
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (32'(count_q) == QUEUE_DEPTH);
	assign valid   = (count_q != '0);
	assign rd_data = slot_q[rd_ptr_q];
	assign do_push = wr.push && !wr.full;
	assign do_pop  = rd.pop && rd.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== design/txcon_back.sv =====
module txcon_back import txcon_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_data,
	input  logic      q_valid,
	input  cmd_t      q_data,
	output q_rd_t     q_rd,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	state_t            state_q, state_d;
	logic [15:0]       mem [CELLS];
	logic [15:0]       rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;

	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ADDR_W-1:0] sw_q, sw_d;
	logic              pend_q, pend_d;
	logic [7:0]        ch_q, ch_d;
	logic [15:0]       cell_q, cell_d;
	logic [7:0]        color_q;
	logic              copy_v_s1, copy_v_d;
	logic [ADDR_W-1:0] copy_addr_s1, copy_addr_d;
	logic              pop;
	logic              load_out;
	logic              wrap;
	out_item_t         out_q;
	logic [31:0]       row_ext;
	logic [31:0]       col_ext;

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign q_rd.pop   = pop;
	assign q_rd.valid = q_valid;
	assign load_out = (state_q == ST_DONE) && (!out_valid || out_ready);
	assign wrap     = (row_q == ROW_W'(ROWS - 1));

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		sw_d        = sw_q;
		pend_d      = pend_q;
		ch_d        = ch_q;
		cell_d      = cell_q;
		copy_v_d    = 1'b0;
		copy_addr_d = copy_addr_s1;
		rd_addr     = q_data.addr;
		mem_we      = 1'b0;
		mem_waddr   = sw_q;
		mem_wdata   = {color_q, SPACE_CODE};
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					ch_d   = q_data.ch;
					cell_d = '0;
					pend_d = 1'b0;
					unique case (q_data.kind)
						CMD_CHAR, CMD_NEWLINE: begin
							if (q_data.kind == CMD_CHAR && col_q < COL_W'(COLUMNS)) begin
								state_d = ST_WRITE;
							end else begin
								pend_d = (q_data.kind == CMD_CHAR);
								col_d  = '0;
								if (!wrap) begin
									row_d   = row_q + 1'b1;
									state_d = (q_data.kind == CMD_CHAR) ? ST_WRITE : ST_DONE;
								end else begin
									sw_d    = '0;
									state_d = ST_SCROLL;
								end
							end
						end
						CMD_CLEAR: begin
							sw_d    = '0;
							state_d = ST_BLANK;
						end
						CMD_READ: begin
							state_d = ST_READ;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_READ: begin
				cell_d  = rd_data_q;
				state_d = ST_DONE;
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
				mem_wdata = {color_q, ch_q};
				col_d     = col_q + 1'b1;
				state_d   = ST_DONE;
			end
			ST_SCROLL: begin
				rd_addr   = ADDR_W'(32'(sw_q) + COLUMNS);
				mem_we    = copy_v_s1;
				mem_waddr = copy_addr_s1;
				mem_wdata = rd_data_q;
				if (32'(sw_q) != SCROLL_END) begin
					copy_v_d    = 1'b1;
					copy_addr_d = sw_q;
					sw_d        = sw_q + 1'b1;
				end else if (!copy_v_s1) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				mem_we = 1'b1;
				if (32'(sw_q) == CELLS - 1) begin
					state_d = pend_q ? ST_WRITE : ST_DONE;
				end else begin
					sw_d = sw_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_q     <= '0;
			col_q     <= '0;
			pend_q    <= 1'b0;
			copy_v_s1 <= 1'b0;
			color_q   <= COLOR_RESET;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			col_q     <= col_d;
			pend_q    <= pend_d;
			copy_v_s1 <= copy_v_d;
			if (cfg_we) begin
				color_q <= cfg_data;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign row_ext = 32'(row_q);
	assign col_ext = 32'(col_q);

	always_ff @(posedge clk) begin
		sw_q         <= sw_d;
		ch_q         <= ch_d;
		cell_q       <= cell_d;
		copy_addr_s1 <= copy_addr_d;
		rd_data_q    <= mem[rd_addr];
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (load_out) begin
			out_q.cell_char  <= cell_q[7:0];
			out_q.cell_color <= cell_q[15:8];
			out_q.cursor_row <= row_ext[4:0];
			out_q.cursor_col <= col_ext[6:0];
		end
	end

	assign out_item = out_q;

	a_write_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> col_q < COL_W'(COLUMNS))
		else $error("character write outside the row");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) <= ROWS - 1)
		else $error("cursor row beyond the bottom row");

	a_copy_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		copy_v_s1 |-> state_q == ST_SCROLL)
		else $error("scroll copy outside a scroll");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid && !out_ready) |=> state_q == ST_DONE)
		else $error("result dropped while the output is stalled");

endmodule

// ===== design/text_console_writer_unit.sv =====
// Character-cell text console, ROWS x COLUMNS cells of character and attribute.
// Input channel (in_valid/in_ready/in_item): put character, clear screen, read
// cell. Output channel (out_valid/out_ready/out_item): one item per input item,
// carrying the cell read (zero otherwise) and the cursor after the operation.
// cfg_we/cfg_data write the attribute byte used for new characters and blanks.
// Items pass through a four-entry command queue into a sequencer that owns the
// cell memory (one write port, one registered read port); the sequencer runs one
// item at a time.
// From acceptance, a put or a read steps through the sequencer's idle, work and
// done states; a no-op, an out-of-range read or a newline above the bottom row
// goes from idle straight to done; a clear blanks one cell a cycle; a newline on
// the bottom row scrolls, copying one cell a cycle and then blanking the bottom
// row, and a character that wraps there is then written.
// The sequencer takes a new item from the queue only once it has left its done
// state for the last one, so items are not overlapped.
// Reset clears the cursor to row 0, column 0 and sets the attribute to 15; the
// cell memory is not cleared and holds nothing defined until written.
// When out_ready is low the result is held and the queue keeps accepting until
// it is full, then in_ready drops.
module text_console_writer_unit import txcon_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item
);

	q_wr_t q_wr;
	q_rd_t q_rd;
	cmd_t  push_data;
	cmd_t  head_data;
	logic  q_full;
	logic  q_valid;

	txcon_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_data   (push_data)
	);

	txcon_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (push_data),
		.full    (q_full),
		.rd      (q_rd),
		.valid   (q_valid),
		.rd_data (head_data)
	);

	txcon_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_data    (head_data),
		.q_rd      (q_rd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import txcon_pkg::*; ();

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 20000000;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_data  = 8'd0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_item_t   in_item   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_item;

	text_console_writer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// console state as the block should hold it
	logic [15:0] screen [CELLS];
	bit          written [CELLS];
	int          cur_row = 0;
	int          cur_col = 0;
	logic [7:0]  colour  = COLOR_RESET;
	out_item_t   expected_replies [$];
	out_item_t   want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_req    = 1'b0;
	int hold_left     = 0;
	int cycle_count   = 0;
	int errors        = 0;
	int items_sent    = 0;
	int n_line_feeds  = 0;
	int n_scrolls     = 0;
	int n_wraps       = 0;
	int n_clears      = 0;
	int n_reads       = 0;
	int n_reads_oob   = 0;
	int n_nops        = 0;
	int input_stalls  = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void line_feed();
		cur_col = 0;
		n_line_feeds++;
		if (cur_row < ROWS - 1) begin
			cur_row++;
		end else begin
			for (int i = 0; i < SCROLL_END; i++) begin
				screen[i]  = screen[i + COLUMNS];
				written[i] = written[i + COLUMNS];
			end
			for (int c = 0; c < COLUMNS; c++) begin
				screen[SCROLL_END + c]  = {colour, SPACE_CODE};
				written[SCROLL_END + c] = 1'b1;
			end
			n_scrolls++;
		end
	endfunction

	function automatic void predict_console(input in_item_t it);
		out_item_t res;
		int idx;
		res = '0;
		case (it.operation)
			OP_PUT: begin
				if (it.char_code == NEWLINE_CODE) begin
					line_feed();
				end else begin
					if (cur_col >= COLUMNS) begin
						n_wraps++;
						line_feed();
					end
					idx = cur_row * COLUMNS + cur_col;
					screen[idx]  = {colour, it.char_code};
					written[idx] = 1'b1;
					cur_col++;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					screen[i]  = {colour, SPACE_CODE};
					written[i] = 1'b1;
				end
				n_clears++;
			end
			OP_READ: begin
				if (it.read_row < ROWS && it.read_col < COLUMNS) begin
					idx = it.read_row * COLUMNS + it.read_col;
					res.cell_char  = screen[idx][7:0];
					res.cell_color = screen[idx][15:8];
					n_reads++;
				end else begin
					n_reads_oob++;
				end
			end
			default: n_nops++;
		endcase
		res.cursor_row = cur_row[4:0];
		res.cursor_col = cur_col[6:0];
		expected_replies.push_back(res);
	endfunction

	function automatic in_item_t put_item(input logic [7:0] ch);
		in_item_t it;
		it.operation = OP_PUT;
		it.char_code = ch;
		it.read_row  = 5'($urandom_range(0, 31));
		it.read_col  = 7'($urandom_range(0, 127));
		return it;
	endfunction

	// never address a cell that holds nothing yet
	function automatic in_item_t read_item(input bit near_cursor);
		in_item_t it;
		int mode;
		int r;
		int c;
		mode = $urandom_range(0, 99);
		if (mode < 12) begin
			r = $urandom_range(ROWS, 31);
			c = $urandom_range(0, 127);
		end else if (mode < 24) begin
			r = $urandom_range(0, 31);
			c = $urandom_range(COLUMNS, 127);
		end else begin
			r = ROWS;
			c = 0;
			for (int tries = 0; tries < 8; tries++) begin
				if (near_cursor)
					r = (cur_row > 0 && $urandom_range(0, 1)) ? cur_row - 1 : cur_row;
				else
					r = $urandom_range(0, ROWS - 1);
				c = $urandom_range(0, COLUMNS - 1);
				if (written[r * COLUMNS + c])
					break;
				r = ROWS;
			end
		end
		it.operation = OP_READ;
		it.char_code = 8'($urandom_range(0, 255));
		it.read_row  = 5'(r);
		it.read_col  = 7'(c);
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		if (send_idle_pct > 0)
			while ($urandom_range(0, 99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		predict_console(it);
		items_sent++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		forever begin
			@(negedge clk);
			if (expected_replies.size() == 0)
				break;
		end
		@(posedge clk);
	endtask

	task automatic write_colour(input logic [7:0] value);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		colour = value;
	endtask

	task automatic test_clear_screen();
		send_item(in_item_t'{OP_CLEAR, 8'h00, 5'd0, 7'd0});
		send_item(in_item_t'{OP_READ, 8'h00, 5'd0, 7'd0});
		send_item(in_item_t'{OP_READ, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1)});
	endtask

	task automatic test_put_extremes();
		send_item(put_item(8'h00));
		send_item(put_item(8'hff));
		send_item(put_item(NEWLINE_CODE));
		send_item(put_item(8'h41));
		send_item(in_item_t'{OP_READ, 8'h00, 5'd0, 7'd0});
		send_item(in_item_t'{OP_READ, 8'hff, 5'd0, 7'd1});
		send_item(in_item_t'{OP_READ, 8'h00, 5'd1, 7'd0});
		send_item(in_item_t'{OP_READ, 8'h00, 5'd0, 7'd2});
	endtask

	task automatic test_out_of_range_reads();
		send_item(in_item_t'{OP_READ, 8'h00, 5'(ROWS), 7'd0});
		send_item(in_item_t'{OP_READ, 8'hff, 5'h1f, 7'h7f});
		send_item(in_item_t'{OP_READ, 8'h00, 5'd0, 7'(COLUMNS)});
		send_item(in_item_t'{OP_READ, 8'h00, 5'(ROWS - 1), 7'h7f});
	endtask

	task automatic test_unused_operation();
		send_item(in_item_t'{OP_NONE, 8'hff, 5'h1f, 7'h7f});
		send_item(in_item_t'{OP_NONE, 8'h00, 5'd0, 7'd0});
	endtask

	task automatic test_colour_extremes();
		write_colour(8'h00);
		send_item(put_item(8'h61));
		write_colour(8'hff);
		send_item(put_item(8'h62));
		send_item(in_item_t'{OP_READ, 8'h00, 5'd1, 7'd1});
		send_item(in_item_t'{OP_READ, 8'h00, 5'd1, 7'd2});
		send_item(in_item_t'{OP_CLEAR, 8'hff, 5'h1f, 7'h7f});
		send_item(in_item_t'{OP_READ, 8'h00, 5'd1, 7'd1});
		write_colour(COLOR_RESET);
	endtask

	// hold the output long enough for the queue to fill and stall the input
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		wait_for_results();
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		repeat (16) begin
			if ($urandom_range(0, 1))
				send_item(put_item(8'($urandom_range(0, 255))));
			else
				send_item(read_item(1'b1));
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
		int target;
		int kind;
		int len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = items_sent + count;
		while (items_sent < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				len = $urandom_range(0, 99);
				if (len < 55)
					len = $urandom_range(0, 6);
				else if (len < 67)
					len = COLUMNS;
				else if (len < 77)
					len = $urandom_range(COLUMNS - 2, COLUMNS + 3);
				else
					len = $urandom_range(7, 40);
				repeat (len) send_item(put_item(8'($urandom_range(0, 255))));
				if ($urandom_range(0, 9) < 8)
					send_item(put_item(NEWLINE_CODE));
				repeat ($urandom_range(0, 3)) send_item(read_item(1'b1));
			end else if (kind < 75) begin
				repeat ($urandom_range(1, 4)) send_item(read_item($urandom_range(0, 1)));
			end else if (kind < 80) begin
				repeat ($urandom_range(1, 3)) send_item(put_item(NEWLINE_CODE));
			end else if (kind < 85) begin
				send_item(in_item_t'{OP_NONE, 8'($urandom_range(0, 255)),
					5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))});
			end else if (kind < 87) begin
				send_item(in_item_t'{OP_CLEAR, 8'($urandom_range(0, 255)),
					5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))});
			end else begin
				kind = $urandom_range(0, 3);
				if (kind == OP_READ)
					send_item(read_item(1'b0));
				else
					send_item(in_item_t'{2'(kind), 8'($urandom_range(0, 255)),
						5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))});
			end
		end
		wait_for_results();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic report_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_ready)
			input_stalls++;
		if (arst_n && out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, out_item);
				errors++;
			end else begin
				want = expected_replies.pop_front();
				report_field("cell_char", want.cell_char, out_item.cell_char);
				report_field("cell_color", want.cell_color, out_item.cell_color);
				report_field("cursor_row", 8'(want.cursor_row), 8'(out_item.cursor_row));
				report_field("cursor_col", 8'(want.cursor_col), 8'(out_item.cursor_col));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[text_console_writer_unit] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clear_screen();
		test_put_extremes();
		test_out_of_range_reads();
		test_unused_operation();
		test_colour_extremes();
		test_output_backpressure();
		write_colour(8'h00);
		test_random_traffic(530, 17, 69);
		write_colour(8'hff);
		test_random_traffic(530, 69, 17);
		write_colour(8'($urandom_range(0, 255)));
		test_random_traffic(530, 0, 0);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d items: %0d line feeds, %0d scrolls, %0d wraps, %0d clears",
			items_sent, n_line_feeds, n_scrolls, n_wraps, n_clears);
		$display("%0d cell reads, %0d out of range, %0d no-ops, %0d input stall cycles",
			n_reads, n_reads_oob, n_nops, input_stalls);
		if (errors == 0)
			$display("[text_console_writer_unit] OK");
		else
			$display("[text_console_writer_unit] ERROR");
		$finish;
	end

endmodule

// ===== text_console_writer_unit.f =====
design/txcon_pkg.sv
design/txcon_front.sv
design/txcon_queue.sv
design/txcon_back.sv
design/text_console_writer_unit.sv
tb/sv/tb_top.sv
